// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the box filter rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/bf3_pkg.sv =====
// types, constants and helper functions of the 3x3 box filter
// no dependencies; imported by every module of the filter but bf3_ram
package bf3_pkg;

  localparam int MaxLineWidth = 2048;
  localparam int IndexBits    = 22;
  localparam int LwBits       = 12;
  localparam int ChanBits     = 8;
  localparam int NumChan      = 3;
  localparam int PixBits      = NumChan * ChanBits;
  localparam int DelayDepth   = 2 * MaxLineWidth + 3;
  localparam int AddrBits     = $clog2(DelayDepth);
  localparam int SumBits      = $clog2(9 * (2 ** ChanBits - 1) + 1);
  localparam int CmpBits      = (IndexBits > AddrBits ? IndexBits : AddrBits) + 1;
  localparam int OutDepth     = 4;
  localparam int CntBits      = $clog2(OutDepth + 1);
  localparam int Div9Mul      = 7282;
  localparam int Div9Shift    = 16;
  localparam int ProdBits     = SumBits + Div9Shift;

  localparam logic [LwBits-1:0]   LineWidthReset = LwBits'(640);
  localparam logic [ChanBits-1:0] AlphaOpaque    = '1;

  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [PixBits-1:0]   pix_t;
  typedef logic [IndexBits-1:0] index_t;
  typedef logic [LwBits-1:0]    lw_t;
  typedef logic [SumBits-1:0]   sum_t;

  localparam index_t IndexMax = '1;

  typedef struct packed {
    logic [31:0] pixel_in;
    logic        first_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    index_t      center_index;
  } out_beat_t;

  // stage tag that travels with the delay memory read data
  typedef struct packed {
    logic   shift;
    logic   item;
    logic   has_res;
    index_t center;
  } tag_t;

  // a - d modulo the delay depth, both below the depth
  function automatic addr_t addr_sub(addr_t a, addr_t d);
    logic [AddrBits:0] t;
    t = {1'b0, a} + (AddrBits + 1)'(DelayDepth) - {1'b0, d};
    if (a >= d) begin
      return a - d;
    end
    return t[AddrBits-1:0];
  endfunction

  // floor(s / 9) by reciprocal multiply, exact for s below 2^15
  function automatic logic [ChanBits-1:0] div9(sum_t s);
    logic [ProdBits-1:0] p;
    p = ProdBits'(s) * ProdBits'(Div9Mul);
    return p[Div9Shift +: ChanBits];
  endfunction

endpackage

// ===== hw/rtl/bf3_ram.sv =====
// generic simple dual port ram: one write port, two registered read ports
// no dependencies
module bf3_ram #(
  parameter int Width = 24,
  parameter int Depth = 4099
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/bf3_window.sv =====
// 3x3 window taps, channel sums and divide by nine
// depends on bf3_pkg; row taps come from the delay memory read ports
module bf3_window (
  input  logic               clk,
  input  logic               rst,
  input  bf3_pkg::tag_t      tag,
  input  bf3_pkg::pix_t      pix,
  input  bf3_pkg::pix_t      row1,
  input  bf3_pkg::pix_t      row2,
  output logic               res_valid,
  output bf3_pkg::out_beat_t res
);
  import bf3_pkg::*;

  pix_t   x1, x2;
  pix_t   a1, b1, a2, b2;
  sum_t   sum [NumChan];
  sum_t   sum_r [NumChan];
  index_t center_r;

  always_ff @(posedge clk) begin
    if (tag.item) begin
      x1 <= pix;
      x2 <= x1;
    end
    if (tag.shift) begin
      a1 <= row1;
      b1 <= a1;
      a2 <= row2;
      b2 <= a2;
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sum[c] = SumBits'(pix[c*ChanBits +: ChanBits]) + SumBits'(x1[c*ChanBits +: ChanBits])
             + SumBits'(x2[c*ChanBits +: ChanBits]) + SumBits'(row1[c*ChanBits +: ChanBits])
             + SumBits'(a1[c*ChanBits +: ChanBits]) + SumBits'(b1[c*ChanBits +: ChanBits])
             + SumBits'(row2[c*ChanBits +: ChanBits]) + SumBits'(a2[c*ChanBits +: ChanBits])
             + SumBits'(b2[c*ChanBits +: ChanBits]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= tag.item && tag.has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.item) begin
      sum_r    <= sum;
      center_r <= tag.center;
    end
  end

  always_comb begin
    res.pixel_out    = {AlphaOpaque, div9(sum_r[2]), div9(sum_r[1]), div9(sum_r[0])};
    res.center_index = center_r;
  end

endmodule

// ===== hw/rtl/bf3_ofifo.sv =====
// small result queue between the filter pipeline and the output channel
// depends on bf3_pkg
`include "assert_macros.svh"
module bf3_ofifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  bf3_pkg::out_beat_t        push_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bf3_pkg::out_beat_t        out_data,
  output logic [bf3_pkg::CntBits-1:0] count
);
  import bf3_pkg::*;

  localparam int PtrBits = (OutDepth > 1) ? $clog2(OutDepth) : 1;

  out_beat_t          q [OutDepth];
  logic [PtrBits-1:0] wr_ptr, rd_ptr;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(OutDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(OutDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMP(a_no_overflow, clk, rst, push, (count < CntBits'(OutDepth)) || pop, "result queue overflow")
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count not incremented")
  `ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == $past(count) - 1'b1, "queue count not decremented")

endmodule

// ===== hw/rtl/box_filter_3x3_rgb.sv =====
// 3x3 box filter on a raster stream of 32-bit pixels, one pixel per clock. Pixels go into a
// 4099 x 24 delay memory (one write, two read ports); the previous two and current rows of the
// window come from two reads per pixel plus small tap registers. The input is accepted every
// cycle as long as the four-entry result queue keeps room; after a line_width write it is held
// off in ST_RLD_A and ST_RLD_B while the tap registers are reloaded from memory at the new row
// distance. The memory needs no clearing after reset; no result is given for the first 2*w+2
// pixels after first_pixel, w being line_width capped at 2048.
// depends on bf3_pkg, bf3_ram, bf3_window, bf3_ofifo
`include "assert_macros.svh"
module box_filter_3x3_rgb (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bf3_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bf3_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  bf3_pkg::lw_t       cfg_data
);
  import bf3_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_RLD_A = 3'b010,
    ST_RLD_B = 3'b100
  } state_t;

  state_t              state, state_next;
  lw_t                 line_width;
  addr_t               w_eff, w2, w1p, w2p;
  addr_t               wp, wp_new;
  addr_t               raddr_a, raddr_b;
  index_t              cnt, idx;
  logic                accept;
  logic                cfg_write;
  logic                has_res;
  pix_t                rdata_a, rdata_b;
  pix_t                pix1, row1, row2;
  logic                fwd_a, fwd_b;
  tag_t                tag1;
  logic                res_valid;
  out_beat_t           res;
  logic [CntBits-1:0]  q_count;
  logic [CntBits:0]    occ;

  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (int'(line_width) > MaxLineWidth) begin
      w_eff = addr_t'(MaxLineWidth);
    end else begin
      w_eff = addr_t'(line_width);
    end
    w2  = w_eff << 1;
    w1p = w_eff + 1'b1;
    w2p = w2 + 1'b1;
  end

  assign wp_new = (wp == addr_t'(DelayDepth - 1)) ? '0 : wp + 1'b1;
  assign idx    = in_data.first_pixel ? '0 : cnt;
  assign has_res = CmpBits'(idx) >= (CmpBits'(w2) + CmpBits'(2));

  always_comb begin
    case (state)
      ST_RLD_A: begin
        raddr_a = addr_sub(wp, w1p);
        raddr_b = addr_sub(wp, w2p);
      end
      ST_RLD_B: begin
        raddr_a = addr_sub(wp, w_eff);
        raddr_b = addr_sub(wp, w2);
      end
      default: begin
        raddr_a = addr_sub(wp_new, w_eff);
        raddr_b = addr_sub(wp_new, w2);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN:   state_next = ST_RUN;
      ST_RLD_A: state_next = ST_RLD_B;
      ST_RLD_B: state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
    if (cfg_write) begin
      state_next = ST_RLD_A;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      line_width <= LineWidthReset;
      wp         <= '0;
      cnt        <= '0;
      tag1.shift <= 1'b0;
      tag1.item  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        line_width <= cfg_data;
      end
      if (accept) begin
        wp  <= wp_new;
        cnt <= (idx == IndexMax) ? IndexMax : idx + 1'b1;
      end
      tag1.shift   <= accept || (state != ST_RUN);
      tag1.item    <= accept;
      tag1.has_res <= has_res;
      tag1.center  <= idx - IndexBits'(w_eff) - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    fwd_a        <= accept && (raddr_a == wp_new);
    fwd_b        <= accept && (raddr_b == wp_new);
    if (accept) begin
      pix1 <= in_data.pixel_in[PixBits-1:0];
    end
  end

  bf3_ram #(
    .Width(PixBits),
    .Depth(DelayDepth)
  ) u_delay (
    .clk     (clk),
    .we      (accept),
    .waddr   (wp_new),
    .wdata   (in_data.pixel_in[PixBits-1:0]),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign row1 = fwd_a ? pix1 : rdata_a;
  assign row2 = fwd_b ? pix1 : rdata_b;

  bf3_window u_window (
    .clk       (clk),
    .rst       (rst),
    .tag       (tag1),
    .pix       (pix1),
    .row1      (row1),
    .row2      (row2),
    .res_valid (res_valid),
    .res       (res)
  );

  bf3_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

  // queue entries plus results still in the pipeline
  assign occ = (CntBits + 1)'(q_count) + (CntBits + 1)'(tag1.item && tag1.has_res)
             + (CntBits + 1)'(res_valid);
  assign in_ready = !rst && (state == ST_RUN) && (occ < (CntBits + 1)'(OutDepth));

  `ASSERT_NEXT(a_beat_reaches_window, clk, rst, accept, tag1.item && tag1.shift, "beat lost")
  `ASSERT_NEXT(a_cfg_reloads_taps, clk, rst, cfg_write, state == ST_RLD_A, "no tap reload")
  `ASSERT_IMP(a_occupancy_bound, clk, rst, 1'b1, occ <= (CntBits + 1)'(OutDepth), "no room")

endmodule

// ===== test/tb_box_filter_3x3_rgb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for box_filter_3x3_rgb: random and corner pixel streams at many widths
// depends on bf3_pkg and the filter rtl; a scoreboard class predicts every 3x3 mean
module tb_box_filter_3x3_rgb;
  import bf3_pkg::*;

  localparam int CycleLimit = 200000;

  class box_mean_board;
    logic [PixBits-1:0] delay_mem [DelayDepth];
    int                 wr_pos;
    index_t             next_index;
    lw_t                line_width;
    out_beat_t          expected_means[$];
    int                 errors;
    int                 results_seen;

    function new();
      wr_pos       = 0;
      next_index   = '0;
      line_width   = LineWidthReset;
      errors       = 0;
      results_seen = 0;
      foreach (delay_mem[i]) delay_mem[i] = '0;
    endfunction

    function void set_width(lw_t w);
      line_width = w;
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void take_pixel(in_beat_t beat);
      int        w;
      int        back_dist;
      int        sr;
      int        sg;
      int        sb;
      index_t    idx;
      logic [PixBits-1:0] v;
      out_beat_t e;
      w   = (int'(line_width) > MaxLineWidth) ? MaxLineWidth : int'(line_width);
      idx = beat.first_pixel ? '0 : next_index;
      wr_pos = (wr_pos + 1) % DelayDepth;
      delay_mem[wr_pos] = beat.pixel_in[PixBits-1:0];
      next_index = (idx != IndexMax) ? idx + 1'b1 : idx;
      if (int'(idx) < 2 * w + 2) begin
        return;
      end
      sr = 0;
      sg = 0;
      sb = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          back_dist = w + 1 - dx - dy * w;
          v = delay_mem[(wr_pos + DelayDepth - back_dist) % DelayDepth];
          sb += v[7:0];
          sg += v[15:8];
          sr += v[23:16];
        end
      end
      e.pixel_out    = {AlphaOpaque, 8'(sr / 9), 8'(sg / 9), 8'(sb / 9)};
      e.center_index = index_t'(int'(idx) - w - 1);
      expected_means.push_back(e);
    endfunction

    task match_result(out_beat_t got);
      out_beat_t e;
      results_seen++;
      if (expected_means.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h idx %0d", got.pixel_out,
                                got.center_index));
        return;
      end
      e = expected_means.pop_front();
      if (got.pixel_out !== e.pixel_out) begin
        flag_mismatch($sformatf("pixel_out %h, want %h (centre %0d)", got.pixel_out,
                                e.pixel_out, e.center_index));
      end
      if (got.center_index !== e.center_index) begin
        flag_mismatch($sformatf("center_index %0d, want %0d", got.center_index,
                                e.center_index));
      end
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  lw_t       cfg_data  = '0;

  box_mean_board board;
  bit            calm      = 1'b0;
  int            hold_left = 0;
  int            cycle_count = 0;
  int            pixels_sent = 0;
  int            width_writes = 0;

  box_filter_3x3_rgb u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.match_result(out_data);
    end
  end

  task automatic send_pixel(input logic [31:0] pix, input logic first);
    in_beat_t beat;
    beat.pixel_in    = pix;
    beat.first_pixel = first;
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    board.take_pixel(beat);
    pixels_sent++;
    @(posedge clk);
  endtask

  task automatic write_width(input lw_t w);
    while (board.expected_means.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    board.set_width(w);
    width_writes++;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one stretch of pixels at one width; restart opens a new image
  task automatic run_phase(input bit write_cfg, input lw_t w, input bit restart,
                           input int count);
    logic [31:0] pix;
    logic        first;
    if (write_cfg) begin
      write_width(w);
    end
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0:       pix = '1;
        1:       pix = '0;
        default: pix = $urandom;
      endcase
      first = (n == 0 && restart) || ($urandom_range(199) == 0);
      send_pixel(pix, first);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] corner_words [25];
    int   random_items;
    lw_t  w;
    corner_words = '{
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'hFF000000, 32'h00FF0000, 32'h0000FF00, 32'h000000FF, 32'h80808080,
      32'h7F7F7F7F, 32'h01020304, 32'hFEFEFEFE, 32'h55AA55AA, 32'hAA55AA55
    };
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset width of 640, no register write yet, too short for a result
    run_phase(1'b0, LineWidthReset, 1'b1, 60);

    // corner pixels at the smallest legal width, with a restart part way
    write_width(lw_t'(3));
    for (int n = 0; n < 25; n++) begin
      send_pixel(corner_words[n], n == 0 || n == 19);
    end
    in_valid <= 1'b0;

    // widths below three overlap the window on itself
    run_phase(1'b1, lw_t'(0), 1'b1, 12);
    run_phase(1'b1, lw_t'(1), 1'b1, 15);
    run_phase(1'b1, lw_t'(2), 1'b1, 20);

    // full width, then an over-range width mid-image
    run_phase(1'b1, lw_t'(MaxLineWidth), 1'b1, 40);
    run_phase(1'b1, '1, 1'b0, 30);

    // no idling on either side for one image
    calm = 1'b1;
    run_phase(1'b1, lw_t'(7), 1'b1, 150);
    calm = 1'b0;

    // receiver holds off while the sender keeps going
    write_width(lw_t'(4));
    hold_left = 150;
    run_phase(1'b0, lw_t'(4), 1'b1, 300);

    random_items = 0;
    while (random_items < 220) begin
      case ($urandom_range(11))
        0:       w = lw_t'($urandom_range(0, 2));
        1:       w = lw_t'($urandom_range(30, 60));
        default: w = lw_t'($urandom_range(3, 24));
      endcase
      begin
        int count;
        count = 2 * int'(w) + 3 + $urandom_range(0, 60);
        run_phase(1'b1, w, $urandom_range(4) != 0, count);
        random_items += count;
      end
    end

    while (board.expected_means.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d pixels over %0d width settings, checked %0d filtered results",
             pixels_sent, width_writes, board.results_seen);
    $display("widths 0 to 4095, image restarts, mid-image width changes, long output stall");
    if (board.errors == 0 && board.expected_means.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
